// File: rtl/word_spread_keyword_scanner_unit_defines.svh
// ---------------------------------------------------------------------------
// word spread keyword scanner assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef WORD_SPREAD_KEYWORD_SCANNER_UNIT_DEFINES_SVH
`define WORD_SPREAD_KEYWORD_SCANNER_UNIT_DEFINES_SVH

// condition that holds at every clock edge out of reset
`define WSKS_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence that holds in the cycle after the trigger
`define WSKS_ASSERT_NEXT(name, trig, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/wsks_pkg.sv
// ---------------------------------------------------------------------------
// wsks_pkg
// types, keyword codes and window check function for the keyword scanner
// ---------------------------------------------------------------------------
`default_nettype none

package wsks_pkg;

  localparam int unsigned WIN_DEPTH = 16;
  localparam int unsigned FILL_W    = 5;
  localparam int unsigned WIN_BITS  = WIN_DEPTH * 8;

  typedef enum logic [2:0] {
    KW_HEAD = 3'd0,
    KW_END  = 3'd1,
    KW_MODL = 3'd2,
    KW_CNTB = 3'd3,
    KW_PRIM = 3'd4,
    KW_CNTE = 3'd5,
    KW_COLR = 3'd6
  } kw_code_t;

  typedef enum logic [1:0] {
    EV_WAIT,
    EV_SLIDE,
    EV_MATCH
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t kind;
    kw_code_t code;
  } ev_result_t;

  // result of scanning one byte, handed from matcher to top level
  typedef struct packed {
    logic              hit;
    kw_code_t          code;
    logic [FILL_W-1:0] keep;
  } scan_t;

  // four-letter keywords, one character per word
  function automatic ev_result_t kw_lookup(input logic [31:0] chars);
    ev_result_t r;
    r.kind = EV_MATCH;
    r.code = KW_HEAD;
    unique case (chars)
      "HEAD":  r.code = KW_HEAD;
      "MODL":  r.code = KW_MODL;
      "CNTB":  r.code = KW_CNTB;
      "PRIM":  r.code = KW_PRIM;
      "CNTE":  r.code = KW_CNTE;
      "COLR":  r.code = KW_COLR;
      default: r.kind = EV_SLIDE;
    endcase
    return r;
  endfunction

  // judge a window of n bytes (n from 12 to 16), byte i at v[8*i +: 8]
  function automatic ev_result_t eval_window(input logic [WIN_BITS-1:0] v,
                                             input logic [FILL_W-1:0]   n);
    ev_result_t r;
    logic       pad_ok;
    r.kind = EV_SLIDE;
    r.code = KW_HEAD;
    pad_ok = (v[0 +: 24] == 24'd0) && (v[32 +: 24] == 24'd0) && (v[64 +: 24] == 24'd0);
    priority if (!pad_ok) begin
      r.kind = EV_SLIDE;
    end else if ({v[24 +: 8], v[56 +: 8], v[88 +: 8]} == "END") begin
      r.kind = EV_MATCH;
      r.code = KW_END;
    end else if (n < FILL_W'(13)) begin
      r.kind = EV_WAIT;
    end else if (v[96 +: 8] != 8'd0) begin
      r.kind = EV_SLIDE;
    end else if (n < FILL_W'(14)) begin
      r.kind = EV_WAIT;
    end else if (v[104 +: 8] != 8'd0) begin
      r.kind = EV_SLIDE;
    end else if (n < FILL_W'(15)) begin
      r.kind = EV_WAIT;
    end else if (v[112 +: 8] != 8'd0) begin
      r.kind = EV_SLIDE;
    end else if (n < FILL_W'(16)) begin
      r.kind = EV_WAIT;
    end else begin
      r = kw_lookup({v[24 +: 8], v[56 +: 8], v[88 +: 8], v[120 +: 8]});
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/word_spread_keyword_scanner_unit.sv
// ---------------------------------------------------------------------------
// word spread keyword scanner unit
// finds chunk identifiers spread one character per big-endian 32-bit word
// ---------------------------------------------------------------------------
//
//   channel  dir  tdata             tuser   tlast       meaning
//   in_      in   [7:0] data_byte   -       stream_end  one stream byte a beat
//   out_     out  [2:0] keyword     found   -           at most one per byte
//
// one byte per cycle when the result side keeps up
// a byte is judged in the cycle it is taken; its result shows next cycle
// in_tready follows out_tready while the output register holds a result
// a result left waiting stalls the input until out_tready
// reset clears the window fill and the output valid; no clearing pass
`default_nettype none

module word_spread_keyword_scanner_unit (
  input  var logic       clk,
  input  var logic       rst_n,
  // input stream
  input  var logic       in_tvalid,
  output logic           in_tready,
  input  var logic [7:0] in_tdata,    // [7:0] data_byte
  input  var logic       in_tlast,    // stream_end
  // result stream
  output logic           out_tvalid,
  input  var logic       out_tready,
  output logic [7:0]     out_tdata,   // [2:0] keyword, [7:3] zero
  output logic           out_tuser    // [0] found
);

  `include "word_spread_keyword_scanner_unit_defines.svh"

  // window history: byte 15 is newest, only the top fill_r bytes count
  logic [wsks_pkg::WIN_BITS-1:0] hist_r;
  logic [wsks_pkg::WIN_BITS-1:0] hist_nxt;
  logic [wsks_pkg::FILL_W-1:0]   fill_r;
  logic [wsks_pkg::FILL_W-1:0]   fill_nxt;

  // result register
  logic                          out_valid_r;
  logic                          out_found_r;
  wsks_pkg::kw_code_t            out_kw_r;

  logic                          in_fire;
  logic                          emit;
  wsks_pkg::scan_t               scan;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  wsks_match u_match (
    .hist      (hist_r),
    .fill      (fill_r),
    .data_byte (in_tdata),
    .scan      (scan)
  );

  // history shifts on every accepted byte; a cleared window just drops fill to zero
  assign hist_nxt = {in_tdata, hist_r[wsks_pkg::WIN_BITS-1:8]};
  // a match or the stream end gives a result and restarts scanning
  assign emit     = scan.hit || in_tlast;
  assign fill_nxt = emit ? '0 : scan.keep;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hist_r <= hist_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (in_fire) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_found_r <= scan.hit;
      out_kw_r    <= scan.hit ? scan.code : wsks_pkg::KW_HEAD;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_kw_r};
  assign out_tuser  = out_found_r;

  // window never holds more than its depth
  `WSKS_ASSERT_ALWAYS(a_fill_range, fill_r <= wsks_pkg::FILL_W'(wsks_pkg::WIN_DEPTH), "window fill out of range")
  // window grows by at most the one byte taken
  `WSKS_ASSERT_NEXT(a_fill_grow, in_fire, fill_r <= $past(fill_r) + 5'd1, "window grew by more than one byte")
  // stream end always restarts the window and posts a result
  `WSKS_ASSERT_NEXT(a_end_clears, in_fire && in_tlast, fill_r == '0 && out_valid_r, "stream end did not restart")
  // not-found results carry keyword zero
  `WSKS_ASSERT_ALWAYS(a_miss_zero, !out_valid_r || out_found_r || out_kw_r == wsks_pkg::KW_HEAD, "not-found result with nonzero keyword")

endmodule

`default_nettype wire

// File: rtl/wsks_match.sv
// ---------------------------------------------------------------------------
// wsks_match
// judges window lengths 12 to 16 bytes in parallel, keeps longest that does not slide
// ---------------------------------------------------------------------------
`default_nettype none

module wsks_match (
  input  var logic [wsks_pkg::WIN_BITS-1:0] hist,      // newest byte at top
  input  var logic [wsks_pkg::FILL_W-1:0]   fill,
  input  var logic [7:0]                    data_byte,
  output wsks_pkg::scan_t                   scan
);

  localparam int unsigned NCAND   = wsks_pkg::WIN_DEPTH - 11;
  localparam int unsigned EXT_W   = wsks_pkg::WIN_BITS + 8 + 8 * (NCAND - 1);
  localparam int unsigned LEN_W   = wsks_pkg::FILL_W + 1;

  logic [EXT_W-1:0]          ext;
  logic [LEN_W-1:0]          ext_len;
  wsks_pkg::ev_result_t      cand_res [NCAND];
  logic [NCAND-1:0]          cand_ok;

  // bytes 0..16: old history then the new byte, zero above
  assign ext     = {{(8 * (NCAND - 1)){1'b0}}, data_byte, hist};
  assign ext_len = LEN_W'(fill) + LEN_W'(1);

  // candidate k is the window of the newest 16-k bytes
  for (genvar k = 0; k < NCAND; k++) begin : g_cand
    assign cand_ok[k]  = ext_len >= LEN_W'(wsks_pkg::WIN_DEPTH - k);
    assign cand_res[k] = wsks_pkg::eval_window(ext[8 * (1 + k) +: wsks_pkg::WIN_BITS],
                                               wsks_pkg::FILL_W'(wsks_pkg::WIN_DEPTH - k));
  end

  always_comb begin
    logic done;
    done      = 1'b0;
    scan.hit  = 1'b0;
    scan.code = wsks_pkg::KW_HEAD;
    // short windows always wait
    scan.keep = (ext_len > LEN_W'(11)) ? wsks_pkg::FILL_W'(11) : wsks_pkg::FILL_W'(ext_len);
    for (int k = 0; k < NCAND; k++) begin
      if (!done && cand_ok[k] && cand_res[k].kind != wsks_pkg::EV_SLIDE) begin
        done      = 1'b1;
        scan.hit  = (cand_res[k].kind == wsks_pkg::EV_MATCH);
        scan.code = cand_res[k].code;
        scan.keep = wsks_pkg::FILL_W'(wsks_pkg::WIN_DEPTH - k);
      end
    end
  end

endmodule

`default_nettype wire

// File: dv/wsks_tb_pkg.sv
// ---------------------------------------------------------------------------
// wsks_tb_pkg
// keyword scan predictor and result checker for the scanner testbench
// ---------------------------------------------------------------------------
package wsks_tb_pkg;

  import wsks_pkg::*;

  typedef struct packed {
    logic     found;
    kw_code_t keyword;
  } keyword_hit_t;

  class keyword_scoreboard;

    logic [7:0]   win [16];
    int unsigned  fill;
    keyword_hit_t pending_hits [$];
    int           errors;

    function new();
      errors = 0;
      clear_window();
    endfunction

    function void clear_window();
      foreach (win[i]) win[i] = 8'd0;
      fill = 0;
    endfunction

    function void drop_oldest();
      for (int i = 0; i < 15; i++) win[i] = win[i + 1];
      win[15] = 8'd0;
      if (fill > 0) fill--;
    endfunction

    // judge the current window: wait for more bytes, slide by one, or match
    function ev_kind_t judge(output kw_code_t code);
      logic [31:0] chars;
      code = KW_HEAD;
      if (fill < 12) return EV_WAIT;
      for (int i = 0; i < 3; i++) begin
        if (win[4*i] != 8'd0 || win[4*i+1] != 8'd0 || win[4*i+2] != 8'd0) return EV_SLIDE;
      end
      if (win[3] == "E" && win[7] == "N" && win[11] == "D") begin
        code = KW_END;
        return EV_MATCH;
      end
      // fourth word padding is judged byte by byte as it arrives
      for (int i = 0; i < 3; i++) begin
        if (fill < 13 + i) return EV_WAIT;
        if (win[12 + i] != 8'd0) return EV_SLIDE;
      end
      if (fill < 16) return EV_WAIT;
      chars = {win[3], win[7], win[11], win[15]};
      case (chars)
        "HEAD":  code = KW_HEAD;
        "MODL":  code = KW_MODL;
        "CNTB":  code = KW_CNTB;
        "PRIM":  code = KW_PRIM;
        "CNTE":  code = KW_CNTE;
        "COLR":  code = KW_COLR;
        default: return EV_SLIDE;
      endcase
      return EV_MATCH;
    endfunction

    // one accepted input beat
    function void note_byte(logic [7:0] b, logic last);
      ev_kind_t     ev;
      kw_code_t     code;
      keyword_hit_t hit;
      if (fill >= 16) drop_oldest();
      win[fill[3:0]] = b;
      fill++;
      do begin
        ev = judge(code);
        if (ev == EV_SLIDE) drop_oldest();
      end while (ev == EV_SLIDE);
      if (ev == EV_MATCH) begin
        hit.found   = 1'b1;
        hit.keyword = code;
        pending_hits.push_back(hit);
        clear_window();
      end else if (last) begin
        hit.found   = 1'b0;
        hit.keyword = KW_HEAD;
        pending_hits.push_back(hit);
        clear_window();
      end
    endfunction

    task report(string what);
      $display("%0t mismatch: %s", $time, what);
      errors++;
    endtask

    // one accepted result beat
    task check_result(logic [7:0] tdata, logic tuser);
      keyword_hit_t want;
      if (pending_hits.size() == 0) begin
        report($sformatf("unexpected result found=%0b tdata=%02h", tuser, tdata));
        return;
      end
      want = pending_hits.pop_front();
      if (tuser !== want.found)
        report($sformatf("found %0b, want %0b", tuser, want.found));
      if (tdata !== {5'd0, want.keyword})
        report($sformatf("keyword tdata %02h, want %02h", tdata, {5'd0, want.keyword}));
    endtask

    function int pending();
      return pending_hits.size();
    endfunction

  endclass

endpackage

// File: dv/word_spread_keyword_scanner_unit_tb.sv
// ---------------------------------------------------------------------------
// word_spread_keyword_scanner_unit_tb
// streams bytes holding word-spread chunk identifiers into the scanner,
// predicts each keyword or not-found result and checks every result beat
// ---------------------------------------------------------------------------
module word_spread_keyword_scanner_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import wsks_pkg::*;
  import wsks_tb_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;    // [7:0] data_byte
  logic       in_tlast;    // stream_end
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;   // [2:0] keyword, [7:3] zero
  logic       out_tuser;   // [0] found

  keyword_scoreboard scan_board;

  int   bytes_sent;
  int   results_taken;
  // calm phases run back to back with no random idle gaps; fixed hold-offs still apply
  logic sender_calm;
  logic receiver_calm;

  word_spread_keyword_scanner_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // one input beat, with a random idle gap in front of it
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if ($urandom_range(0, 29) == 0) sender_calm = !sender_calm;
    gap = sender_calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    scan_board.note_byte(b, last);
    bytes_sent++;
  endtask

  // a run of bytes, stream end optionally flagged on the final one
  task automatic send_run(input logic [7:0] q[$], input logic last_at_end);
    foreach (q[i]) send_byte(q[i], last_at_end && (i == q.size() - 1));
  endtask

  // characters from chars[31:24] down, each behind three zero pad bytes
  function automatic void add_spread(ref logic [7:0] q[$], input logic [31:0] chars,
                                     input int nwords);
    for (int w = 0; w < nwords; w++) begin
      q.push_back(8'd0);
      q.push_back(8'd0);
      q.push_back(8'd0);
      q.push_back(chars[31 - 8*w -: 8]);
    end
  endfunction

  // result side: random ready gaps, long hold-offs to back up the input
  task automatic take_results();
    int gap;
    forever begin
      if ($urandom_range(0, 29) == 0) receiver_calm = !receiver_calm;
      gap = receiver_calm ? 0 : $urandom_range(0, 19);
      if (results_taken == 12 || results_taken == 40) gap = 400;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      scan_board.check_result(out_tdata, out_tuser);
      results_taken++;
    end
  endtask

  initial begin
    logic [7:0]  q[$];
    logic [31:0] chars;
    int          nwords;
    int          pick;
    int          seq_count;
    int          pos;
    string       letters;

    letters       = "HEADNMOLCTBPRIX";
    scan_board    = new();
    bytes_sent    = 0;
    results_taken = 0;
    seq_count     = 0;
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;

    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= 8'd0;
    in_tlast   <= 1'b0;
    out_tready <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    fork
      take_results();
    join_none

    // short END keyword, completed by the stream's final beat: match only
    q = {};
    add_spread(q, {"END", 8'h00}, 3);
    send_run(q, 1'b1);
    // lone all-ones beat closing a stream: not found
    send_byte(8'hFF, 1'b1);
    // three padded words that are not END, then nonzero fourth pad
    q = {};
    add_spread(q, {"ENX", 8'h00}, 3);
    q.push_back(8'h01);
    send_run(q, 1'b1);

    // random part, mostly well-formed identifiers with random surroundings
    while (bytes_sent < 650) begin
      pick = $urandom_range(0, 99);
      q = {};
      if (pick < 60) begin
        repeat ($urandom_range(0, 3))
          q.push_back($urandom_range(0, 1) ? 8'd0 : 8'($urandom));
        // the first seven keyword runs walk every keyword code in turn
        case (kw_code_t'((seq_count < 7) ? seq_count : $urandom_range(0, 6)))
          KW_HEAD: begin chars = "HEAD";           nwords = 4; end
          KW_END:  begin chars = {"END", 8'h00};   nwords = 3; end
          KW_MODL: begin chars = "MODL";           nwords = 4; end
          KW_CNTB: begin chars = "CNTB";           nwords = 4; end
          KW_PRIM: begin chars = "PRIM";           nwords = 4; end
          KW_CNTE: begin chars = "CNTE";           nwords = 4; end
          default: begin chars = "COLR";           nwords = 4; end
        endcase
        add_spread(q, chars, nwords);
        seq_count++;
        // flip bits in one byte, pad or character
        if ($urandom_range(0, 4) == 0) begin
          pos = $urandom_range(0, q.size() - 1);
          q[pos] = q[pos] ^ 8'($urandom_range(1, 255));
        end
        // cut short, often ends a stream mid-pattern
        if ($urandom_range(0, 5) == 0) q = q[0 : $urandom_range(0, q.size() - 2)];
        send_run(q, $urandom_range(0, 3) == 0);
      end else if (pick < 80) begin
        // near misses built from keyword letters
        for (int i = 0; i < 4; i++) chars[31 - 8*i -: 8] = letters[$urandom_range(0, 14)];
        if ($urandom_range(0, 2) == 0) chars[31:8] = "CNT";
        else if ($urandom_range(0, 2) == 0) chars[31:16] = "EN";
        add_spread(q, chars, $urandom_range(0, 3) == 0 ? 3 : 4);
        send_run(q, $urandom_range(0, 4) == 0);
      end else begin
        repeat ($urandom_range(1, 6))
          send_byte($urandom_range(0, 1) ? 8'd0 : 8'($urandom), $urandom_range(0, 9) == 0);
      end
    end
    in_tvalid <= 1'b0;

    while (scan_board.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (scan_board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/wsks_pkg.sv
rtl/wsks_match.sv
rtl/word_spread_keyword_scanner_unit.sv
dv/wsks_tb_pkg.sv
dv/word_spread_keyword_scanner_unit_tb.sv
